### rtl/core/sel_pkg.sv
// shared types, constants and state encodings for the stripe edge subpixel locator
// used by sel_row_track, sel_divider and stripe_edge_subpixel_locator_top
`default_nettype none

package sel_pkg;

    // field widths
    localparam int PIX_W      = 8;
    localparam int WGT_W      = 10;
    localparam int RESP_W     = 11;
    localparam int ROW_W      = 6;
    localparam int OFF_W      = 10;

    // default stripe length limit
    localparam int MAX_ROWS_DEF = 63;

    // offset saturation limit, 1/256 row units
    localparam int OFF_SAT    = 256;

    // divider sizes: dividend 2*128*|y0-y2| + |curv|, divisor 2*|curv|
    localparam int DIFF_W     = RESP_W + 1;
    localparam int CURV_W     = RESP_W + 2;
    localparam int DIV_N_W    = 20;
    localparam int DIV_D_W    = 13;
    localparam int DIV_CNT_W  = $clog2(DIV_N_W);

    // peak summary handed from the row tracker to the sequencer
    typedef struct packed {
        logic [ROW_W-1:0]         row;
        logic signed [RESP_W-1:0] best;
        logic signed [RESP_W-1:0] left;
        logic signed [RESP_W-1:0] right;
        logic                     short_stripe;
    } t_peak;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_top_state;

    typedef enum logic [1:0] {
        D_IDLE,
        D_PREP,
        D_RUN,
        D_DONE
    } t_div_state;

endpackage

`default_nettype wire

### rtl/core/stripe_edge_subpixel_locator_top.sv
// Stripe edge subpixel locator. Rows of a three-pixel-wide grey stripe arrive one
// beat per cycle while o_in_ready is high; each window of three rows gives a
// vertical sobel response and the strongest one (later row on ties) is kept with
// its two neighbours. On the last row one result beat carries the peak row, its
// strength and the parabolic vertex offset in 1/256 row, saturated to one row.
// After the last row of a stripe the input stays stalled while the sequencer
// prepares, runs the 20 steps of the shared restoring divider at one quotient bit
// per cycle, finishes and hands the result on. A flat peak skips the divider steps
// and a short stripe skips the divider entirely. The result sits in an output
// register, so the next stripe may stream in while it waits to be taken; a stripe
// that ends while that register is still full stalls the input until it is taken.
// depends on sel_pkg, sel_row_track and sel_divider
`default_nettype none

module stripe_edge_subpixel_locator_top
    import sel_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [PIX_W-1:0]        i_left_pixel,
    input  wire logic [PIX_W-1:0]        i_centre_pixel,
    input  wire logic [PIX_W-1:0]        i_right_pixel,
    input  wire logic                    i_last_row,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [ROW_W-1:0]             o_peak_row,
    output logic signed [RESP_W-1:0]     o_peak_strength,
    output logic signed [OFF_W-1:0]      o_subpixel_offset,
    output logic                         o_flat_peak,
    output logic                         o_short_stripe
);

    t_top_state r_state, n_state;

    t_peak                    peak;
    logic                     in_accept;
    logic                     out_free;
    logic                     div_start;
    logic                     div_done;
    logic signed [OFF_W-1:0]  div_offset;
    logic                     div_flat;
    logic                     load_out;

    logic [ROW_W-1:0]         r_res_row;
    logic signed [RESP_W-1:0] r_res_str;
    logic signed [OFF_W-1:0]  r_res_off;
    logic                     r_res_flat;
    logic                     r_res_short;

    logic                     r_out_valid;
    logic [ROW_W-1:0]         r_out_row;
    logic signed [RESP_W-1:0] r_out_str;
    logic signed [OFF_W-1:0]  r_out_off;
    logic                     r_out_flat;
    logic                     r_out_short;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;

    sel_row_track #(
        .MAX_ROWS(MAX_ROWS)
    ) u_row_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_left_pixel   (i_left_pixel),
        .i_centre_pixel (i_centre_pixel),
        .i_right_pixel  (i_right_pixel),
        .i_last_row     (i_last_row),
        .o_peak         (peak)
    );

    sel_divider u_divider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_y0     (peak.left),
        .i_y1     (peak.best),
        .i_y2     (peak.right),
        .o_done   (div_done),
        .o_offset (div_offset),
        .o_flat   (div_flat)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && i_last_row) begin
                    n_state = peak.short_stripe ? S_HOLD : S_DIV;
                end
            end
            S_DIV:  if (div_done) n_state = S_HOLD;
            S_HOLD: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                div_start  = i_in_valid && i_last_row && !peak.short_stripe;
            end
            S_HOLD:  load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // result held between the last row and the output register
    always_ff @(posedge i_clk) begin
        if (in_accept && i_last_row) begin
            r_res_short <= peak.short_stripe;
            r_res_row   <= peak.short_stripe ? '0 : peak.row;
            r_res_str   <= peak.short_stripe ? '0 : peak.best;
            r_res_off   <= '0;
            r_res_flat  <= 1'b0;
        end else if (r_state == S_DIV && div_done) begin
            r_res_off  <= div_offset;
            r_res_flat <= div_flat;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_row   <= r_res_row;
            r_out_str   <= r_res_str;
            r_out_off   <= r_res_off;
            r_out_flat  <= r_res_flat;
            r_out_short <= r_res_short;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_peak_row        = r_out_row;
    assign o_peak_strength   = r_out_str;
    assign o_subpixel_offset = r_out_off;
    assign o_flat_peak       = r_out_flat;
    assign o_short_stripe    = r_out_short;

    // divider finishes only while the sequencer waits on it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider done outside divide state");

    // a short stripe beat carries zero fields
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_short) |-> (r_out_row == '0 && r_out_str == '0
            && r_out_off == '0 && !r_out_flat))
        else $error("short stripe beat with nonzero fields");

    // offset stays within one row
    a_off_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_off <= $signed(OFF_W'(OFF_SAT))
            && r_out_off >= -$signed(OFF_W'(OFF_SAT))))
        else $error("subpixel offset out of range");

    // flat peak forces a zero offset
    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_flat) |-> (r_out_off == '0))
        else $error("flat peak with nonzero offset");

endmodule

`default_nettype wire

### rtl/core/sel_row_track.sv
// row tracker: vertical sobel response per row window and peak with neighbours
// depends on sel_pkg
`default_nettype none

module sel_row_track
    import sel_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [PIX_W-1:0] i_left_pixel,
    input  wire logic [PIX_W-1:0] i_centre_pixel,
    input  wire logic [PIX_W-1:0] i_right_pixel,
    input  wire logic             i_last_row,
    output t_peak                 o_peak
);

    localparam int RS_W  = $clog2(MAX_ROWS + 1);
    localparam int IDX_W = $clog2(MAX_ROWS - 2);

    logic [WGT_W-1:0]         r_wgt_one, n_wgt_one;
    logic [WGT_W-1:0]         r_wgt_two, n_wgt_two;
    logic [RS_W-1:0]          r_rows, n_rows;
    logic signed [RESP_W-1:0] r_best, n_best;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic signed [RESP_W-1:0] r_left, n_left;
    logic signed [RESP_W-1:0] r_right, n_right;
    logic                     r_await, n_await;
    logic signed [RESP_W-1:0] r_prev, n_prev;

    logic [WGT_W-1:0]         in_wgt;
    logic signed [RESP_W-1:0] resp;
    logic                     first_win;
    logic [IDX_W+ROW_W-1:0]   idx_ext;

    // weighted row sum 1,2,1 and the response against the row two back
    assign in_wgt = WGT_W'(i_left_pixel) + {1'b0, i_centre_pixel, 1'b0}
                  + WGT_W'(i_right_pixel);
    assign resp   = $signed({1'b0, r_wgt_two}) - $signed({1'b0, in_wgt});
    assign first_win = (r_rows == RS_W'(2));

    // next stripe state for an accepted row
    always_comb begin
        n_wgt_one = r_wgt_one;
        n_wgt_two = r_wgt_two;
        n_rows    = r_rows;
        n_best    = r_best;
        n_idx     = r_idx;
        n_left    = r_left;
        n_right   = r_right;
        n_await   = r_await;
        n_prev    = r_prev;
        if (r_rows < RS_W'(MAX_ROWS)) begin
            if (r_rows >= RS_W'(2)) begin
                if (first_win || (resp >= r_best)) begin
                    n_best  = resp;
                    n_idx   = IDX_W'(r_rows - RS_W'(2));
                    n_left  = first_win ? '0 : r_prev;
                    n_right = '0;
                    n_await = 1'b1;
                end else if (r_await) begin
                    n_right = resp;
                    n_await = 1'b0;
                end
                n_prev = resp;
            end
            n_wgt_two = r_wgt_one;
            n_wgt_one = in_wgt;
            n_rows    = r_rows + RS_W'(1);
        end
    end

    // summary of the stripe as it stands after this row
    assign idx_ext = {{ROW_W{1'b0}}, n_idx};
    always_comb begin
        o_peak.row          = idx_ext[ROW_W-1:0];
        o_peak.best         = n_best;
        o_peak.left         = n_left;
        o_peak.right        = n_right;
        o_peak.short_stripe = (n_rows < RS_W'(3));
    end

    // stripe registers, cleared after the last row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_row)) begin
            r_wgt_one <= '0;
            r_wgt_two <= '0;
            r_rows    <= '0;
            r_best    <= '0;
            r_idx     <= '0;
            r_left    <= '0;
            r_right   <= '0;
            r_await   <= 1'b0;
            r_prev    <= '0;
        end else if (i_accept) begin
            r_wgt_one <= n_wgt_one;
            r_wgt_two <= n_wgt_two;
            r_rows    <= n_rows;
            r_best    <= n_best;
            r_idx     <= n_idx;
            r_left    <= n_left;
            r_right   <= n_right;
            r_await   <= n_await;
            r_prev    <= n_prev;
        end
    end

endmodule

`default_nettype wire

### rtl/core/sel_divider.sv
// shared restoring divider for the parabolic vertex offset, one quotient bit a cycle
// depends on sel_pkg
`default_nettype none

module sel_divider
    import sel_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [RESP_W-1:0] i_y0,
    input  wire logic signed [RESP_W-1:0] i_y1,
    input  wire logic signed [RESP_W-1:0] i_y2,
    output logic                          o_done,
    output logic signed [OFF_W-1:0]       o_offset,
    output logic                          o_flat
);

    t_div_state r_state, n_state;

    logic signed [RESP_W-1:0] r_y0, r_y1, r_y2;
    logic [DIV_N_W-1:0]       r_num;
    logic [DIV_D_W-1:0]       r_den;
    logic [DIV_D_W-1:0]       r_rem;
    logic [DIV_CNT_W-1:0]     r_cnt;
    logic                     r_neg;
    logic                     r_flat;

    logic signed [DIFF_W-1:0] diff;
    logic signed [CURV_W-1:0] curv;
    logic [DIFF_W-1:0]        diff_abs;
    logic [CURV_W-1:0]        curv_abs;
    logic [DIV_N_W-1:0]       prep_num;
    logic [DIV_D_W:0]         rem_shift;
    logic                     rem_ge;
    logic [DIV_D_W:0]         rem_sub;
    logic                     q_sat;
    logic [OFF_W-1:0]         q_mag;

    // numerator 128*(y0-y2) and curvature y0-2y1+y2, taken as magnitude and sign
    assign diff     = DIFF_W'(r_y0) - DIFF_W'(r_y2);
    assign curv     = CURV_W'(r_y0) + CURV_W'(r_y2) - (CURV_W'(r_y1) <<< 1);
    assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign curv_abs = curv[CURV_W-1] ? CURV_W'(-curv) : CURV_W'(curv);
    // dividend 2*|num| + |den| for round half away from zero
    assign prep_num = {diff_abs[DIFF_W-2:0], 8'b0} + DIV_N_W'(curv_abs);

    // one restoring step
    assign rem_shift = {r_rem, r_num[DIV_N_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, r_den});
    assign rem_sub   = rem_shift - {1'b0, r_den};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE: if (i_start) n_state = D_PREP;
            D_PREP: n_state = (curv == '0) ? D_DONE : D_RUN;
            D_RUN:  if (r_cnt == '0) n_state = D_DONE;
            D_DONE: n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_done = 1'b0;
        unique case (r_state)
            D_DONE:  o_done = 1'b1;
            default: o_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_start) begin
            r_y0 <= i_y0;
            r_y1 <= i_y1;
            r_y2 <= i_y2;
        end
        if (r_state == D_PREP) begin
            r_rem  <= '0;
            r_cnt  <= DIV_CNT_W'(DIV_N_W - 1);
            r_den  <= {curv_abs[DIV_D_W-2:0], 1'b0};
            r_neg  <= (diff[DIFF_W-1] != curv[CURV_W-1]);
            r_flat <= (curv == '0);
            r_num  <= (curv == '0) ? '0 : prep_num;
        end else if (r_state == D_RUN) begin
            r_rem <= rem_ge ? rem_sub[DIV_D_W-1:0] : rem_shift[DIV_D_W-1:0];
            r_num <= {r_num[DIV_N_W-2:0], rem_ge};
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    // saturate to one row and apply the sign
    assign q_sat    = (r_num > DIV_N_W'(OFF_SAT));
    assign q_mag    = q_sat ? OFF_W'(OFF_SAT) : OFF_W'(r_num);
    assign o_offset = r_neg ? $signed(OFF_W'(-q_mag)) : $signed(q_mag);
    assign o_flat   = r_flat;

endmodule

`default_nettype wire
